>>> hw/rtl/jfd_pkg.sv
// Package for the joint frame deframer: markers, codes, state types and arithmetic helpers.
`timescale 1ns / 1ps
`default_nettype none

package jfd_pkg;

    localparam int          PAYLOAD_BYTES = 12;

    localparam logic [7:0]  HDR_BYTE      = 8'hA5;
    localparam logic [7:0]  TRL_BYTE      = 8'h66;

    localparam int          CFG_IDX_W     = 2;
    localparam int          SPEED_W       = 13;
    localparam int          ACCEL_W       = 8;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 13'd1000;
    localparam logic [ACCEL_W-1:0] ACCEL_RESET = 8'd0;

    localparam int          TARGET_W      = 3;
    localparam int          PULSE_W       = 17;
    localparam int          SERVO_W       = 18;
    localparam int          PROD_W        = 22;
    localparam int          COEF_W        = 6;
    localparam int          FRAC_SHIFT    = 5;

    // |a| * 25 / 32 for steppers, biased angle * 45 / 32 for servos
    localparam logic [COEF_W-1:0]  STEP_COEF   = 6'd25;
    localparam logic [COEF_W-1:0]  SERVO_COEF  = 6'd45;
    localparam logic [SERVO_W-1:0] SERVO_BIAS  = 18'd23040;

    localparam logic [TARGET_W-1:0] TGT_WRIST   = 3'd4;
    localparam logic [TARGET_W-1:0] TGT_GRIPPER = 3'd5;
    localparam logic [TARGET_W-1:0] SERVO_ANGLE_IDX = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTOR_SPEED = 2'd0,
        CFG_MOTOR_ACCEL = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_TRAILER = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_HI   = 2'd1,
        ST_LO   = 2'd2,
        ST_FORM = 2'd3
    } t_state;

    // Gear ratio of stepper joints one to four
    function automatic logic [2:0] gear_ratio(input logic [1:0] joint);
        logic [2:0] g;
        case (joint)
            2'd0:    g = 3'd4;
            2'd1:    g = 3'd4;
            2'd2:    g = 3'd3;
            default: g = 3'd1;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/joint_frame_deframer.sv
// Top level of the joint frame deframer: byte parser, payload store and command sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Receives serial bytes, one per transfer. A frame is header 0xA5, PAYLOAD_BYTES payload
// bytes and trailer 0x66; stray bytes while waiting for a marker are dropped. A byte that
// does not complete a frame does not stall the input. A trailer starts a decode of six
// commands (four steppers, each on its own angle, then wrist and gripper servos, both on
// angle six): each command reads the high angle byte from the single-read payload store,
// then reads the low byte through the shared constant multiplier, then is scaled and
// registered, and then is presented until it is taken. The input is stalled for the
// whole decode, and the last command's output transfer returns the block to accepting
// bytes. Speed and acceleration are copied into each stepper command; write them only
// while the block is idle.
module joint_frame_deframer #(
    parameter int PAYLOAD_BYTES = jfd_pkg::PAYLOAD_BYTES
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,

    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire  [7:0]                        i_rx_byte,

    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [jfd_pkg::TARGET_W-1:0]      o_target,
    output logic                              o_direction,
    output logic [jfd_pkg::PULSE_W-1:0]       o_pulse_count,
    output logic [jfd_pkg::SPEED_W-1:0]       o_speed,
    output logic [jfd_pkg::ACCEL_W-1:0]       o_accel,
    output logic signed [jfd_pkg::SERVO_W-1:0] o_servo_angle,
    output logic                              o_last,

    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [jfd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [jfd_pkg::SPEED_W-1:0]       i_cfg_data
);

    localparam int CW = $clog2(PAYLOAD_BYTES);

    // Configuration registers
    logic [jfd_pkg::SPEED_W-1:0] r_speed;
    logic [jfd_pkg::ACCEL_W-1:0] r_accel;

    // Parser and sequencer state
    jfd_pkg::t_phase             r_phase, n_phase;
    jfd_pkg::t_state             r_state, n_state;
    logic [CW-1:0]               r_byte_count, n_byte_count;
    logic [jfd_pkg::TARGET_W-1:0] r_cmd, n_cmd;
    logic                        r_out_valid, n_out_valid;

    logic [7:0]                  r_buf [PAYLOAD_BYTES];
    logic [7:0]                  r_hi;
    logic [jfd_pkg::PROD_W-1:0]  r_prod;
    logic                        r_dir;

    logic                        in_xfer;
    logic                        out_xfer;
    logic                        buf_we;
    logic                        servo_cmd;
    logic [jfd_pkg::TARGET_W-1:0] angle_idx;
    logic [CW-1:0]               rd_addr;
    logic [7:0]                  rd_byte;
    logic [15:0]                 raw;
    logic [15:0]                 mag;
    logic [15:0]                 mul_a;
    logic [jfd_pkg::COEF_W-1:0]  mul_b;
    logic [jfd_pkg::PROD_W-1:0]  mul_p;
    logic [jfd_pkg::PULSE_W-1:0] scaled;
    logic [jfd_pkg::PULSE_W-1:0] pulses;
    logic [jfd_pkg::SERVO_W-1:0] servo;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    // hold off bytes until the last command of a decode has gone
    assign o_in_stall  = (r_state != jfd_pkg::ST_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= jfd_pkg::SPEED_RESET;
            r_accel <= jfd_pkg::ACCEL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                jfd_pkg::CFG_MOTOR_SPEED: r_speed <= i_cfg_data;
                jfd_pkg::CFG_MOTOR_ACCEL: r_accel <= i_cfg_data[jfd_pkg::ACCEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Angle address: steppers use their own angle, both servos use angle six
    assign servo_cmd = (r_cmd >= jfd_pkg::TGT_WRIST);
    assign angle_idx = servo_cmd ? jfd_pkg::SERVO_ANGLE_IDX : r_cmd;
    assign rd_addr   = (r_state == jfd_pkg::ST_HI) ? CW'({angle_idx, 1'b0})
                                                   : CW'({angle_idx, 1'b1});
    assign rd_byte   = r_buf[rd_addr];

    // Shared constant multiplier
    assign raw   = {r_hi, rd_byte};
    assign mag   = raw[15] ? 16'(~raw + 16'd1) : raw;
    assign mul_a = servo_cmd ? (raw ^ 16'h8000) : mag;
    assign mul_b = servo_cmd ? jfd_pkg::SERVO_COEF : jfd_pkg::STEP_COEF;
    assign mul_p = jfd_pkg::PROD_W'(mul_a) * jfd_pkg::PROD_W'(mul_b);

    assign scaled = r_prod[jfd_pkg::FRAC_SHIFT +: jfd_pkg::PULSE_W];
    assign pulses = jfd_pkg::PULSE_W'(scaled[14:0] * jfd_pkg::gear_ratio(r_cmd[1:0]));
    assign servo  = {1'b0, scaled} - jfd_pkg::SERVO_BIAS;

    assign buf_we = in_xfer && (r_phase == jfd_pkg::PH_PAYLOAD);

    // Parser and sequencer next state
    always_comb begin
        n_phase      = r_phase;
        n_state      = r_state;
        n_byte_count = r_byte_count;
        n_cmd        = r_cmd;
        n_out_valid  = r_out_valid;

        unique case (r_state)
            jfd_pkg::ST_IDLE: begin
                if (out_xfer) begin
                    n_out_valid = 1'b0;
                    // advance to the next command unless the frame is done
                    if (r_cmd != jfd_pkg::TGT_GRIPPER) begin
                        n_cmd   = r_cmd + 3'd1;
                        n_state = jfd_pkg::ST_HI;
                    end
                end
                if (in_xfer) begin
                    unique case (r_phase)
                        jfd_pkg::PH_PAYLOAD: begin
                            if ({1'b0, r_byte_count} + (CW+1)'(1) >= (CW+1)'(PAYLOAD_BYTES))
                                n_phase = jfd_pkg::PH_TRAILER;
                            else
                                n_byte_count = r_byte_count + CW'(1);
                        end
                        jfd_pkg::PH_TRAILER: begin
                            if (i_rx_byte == jfd_pkg::TRL_BYTE) begin
                                n_phase = jfd_pkg::PH_HEADER;
                                n_cmd   = '0;
                                n_state = jfd_pkg::ST_HI;
                            end
                        end
                        default: begin
                            if (i_rx_byte == jfd_pkg::HDR_BYTE) begin
                                n_phase      = jfd_pkg::PH_PAYLOAD;
                                n_byte_count = '0;
                            end else begin
                                n_phase = jfd_pkg::PH_HEADER;
                            end
                        end
                    endcase
                end
            end
            jfd_pkg::ST_HI: n_state = jfd_pkg::ST_LO;
            jfd_pkg::ST_LO: n_state = jfd_pkg::ST_FORM;
            jfd_pkg::ST_FORM: begin
                n_out_valid = 1'b1;
                n_state     = jfd_pkg::ST_IDLE;
            end
            default: n_state = jfd_pkg::ST_IDLE;
        endcase

        // hold in the command loop while a command waits to be taken
        if (r_out_valid && !out_xfer && r_state == jfd_pkg::ST_IDLE &&
            r_cmd != jfd_pkg::TGT_GRIPPER) begin
            n_state = jfd_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= jfd_pkg::PH_HEADER;
            r_state      <= jfd_pkg::ST_IDLE;
            r_byte_count <= '0;
            r_cmd        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_state      <= n_state;
            r_byte_count <= n_byte_count;
            r_cmd        <= n_cmd;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload store and datapath registers
    always_ff @(posedge i_clk) begin
        if (buf_we)
            r_buf[r_byte_count] <= i_rx_byte;
        if (r_state == jfd_pkg::ST_HI)
            r_hi <= rd_byte;
        if (r_state == jfd_pkg::ST_LO) begin
            r_prod <= mul_p;
            r_dir  <= ~raw[15];
        end
        if (r_state == jfd_pkg::ST_FORM) begin
            o_target <= r_cmd;
            o_last   <= (r_cmd == jfd_pkg::TGT_GRIPPER);
            if (servo_cmd) begin
                o_direction   <= 1'b0;
                o_pulse_count <= '0;
                o_speed       <= '0;
                o_accel       <= '0;
                o_servo_angle <= servo;
            end else begin
                o_direction   <= r_dir;
                o_pulse_count <= pulses;
                o_speed       <= r_speed;
                o_accel       <= r_accel;
                o_servo_angle <= '0;
            end
        end
    end

endmodule

`default_nettype wire

>>> bench/jfd_checker.sv
// Checker for the joint frame deframer: tracks the byte stream, predicts commands, compares.
`timescale 1ns / 1ps

module jfd_checker
    import jfd_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,

    input  wire                       i_in_valid,
    input  wire                       i_in_stall,
    input  wire  [7:0]                i_rx_byte,

    input  wire                       i_out_valid,
    input  wire                       i_out_stall,
    input  wire  [TARGET_W-1:0]       i_target,
    input  wire                       i_direction,
    input  wire  [PULSE_W-1:0]        i_pulse_count,
    input  wire  [SPEED_W-1:0]        i_speed,
    input  wire  [ACCEL_W-1:0]        i_accel,
    input  wire signed [SERVO_W-1:0]  i_servo_angle,
    input  wire                       i_last,

    input  wire                       i_cfg_valid,
    input  wire                       i_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [SPEED_W-1:0]        i_cfg_data,

    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked
);

    localparam int JOINT_GEAR [4] = '{4, 4, 3, 1};
    localparam int WRIST_ANGLE    = 5;     // angle six drives both servos

    typedef struct {
        logic [TARGET_W-1:0]       target;
        logic                      direction;
        logic [PULSE_W-1:0]        pulse_count;
        logic [SPEED_W-1:0]        speed;
        logic [ACCEL_W-1:0]        accel;
        logic signed [SERVO_W-1:0] servo_angle;
        logic                      last;
    } t_joint_cmd;

    t_joint_cmd                cmd_expect_q [$];
    t_phase                    rx_phase;
    int unsigned               rx_count;
    logic [7:0]                payload_buf [PAYLOAD_BYTES];
    logic [SPEED_W-1:0]        speed_reg;
    logic [ACCEL_W-1:0]        accel_reg;
    int                        err_cnt = 0;
    int                        checked_cnt = 0;

    function automatic logic signed [15:0] frame_angle(input int k);
        return {payload_buf[2*k], payload_buf[2*k+1]};
    endfunction

    task automatic queue_joint_commands();
        t_joint_cmd        c;
        logic signed [15:0] ang;
        int                mag;
        int                servo;
        for (int j = 0; j < 4; j++) begin
            ang           = frame_angle(j);
            mag           = (ang < 0) ? -int'(ang) : int'(ang);
            c.target      = TARGET_W'(j);
            c.direction   = (ang >= 0);
            c.pulse_count = PULSE_W'(((mag * 25) >> 5) * JOINT_GEAR[j]);
            c.speed       = speed_reg;
            c.accel       = accel_reg;
            c.servo_angle = '0;
            c.last        = 1'b0;
            cmd_expect_q.push_back(c);
        end
        // 256 * (90 + 180 * a / 32768), floored
        servo         = 23040 + ((45 * int'(frame_angle(WRIST_ANGLE))) >>> 5);
        c.direction   = 1'b0;
        c.pulse_count = '0;
        c.speed       = '0;
        c.accel       = '0;
        c.servo_angle = SERVO_W'(servo);
        c.target      = TGT_WRIST;
        c.last        = 1'b0;
        cmd_expect_q.push_back(c);
        c.target      = TGT_GRIPPER;
        c.last        = 1'b1;
        cmd_expect_q.push_back(c);
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        case (rx_phase)
            PH_PAYLOAD: begin
                payload_buf[rx_count] = b;
                if (rx_count == PAYLOAD_BYTES - 1)
                    rx_phase = PH_TRAILER;
                else
                    rx_count++;
            end
            PH_TRAILER: begin
                if (b == TRL_BYTE) begin
                    queue_joint_commands();
                    rx_phase = PH_HEADER;
                end
            end
            default: begin
                if (b == HDR_BYTE) begin
                    rx_phase = PH_PAYLOAD;
                    rx_count = 0;
                end
            end
        endcase
    endtask

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
            err_cnt++;
        end
    endtask

    task automatic compare_command();
        t_joint_cmd c;
        if (cmd_expect_q.size() == 0) begin
            $error("command transfer with none expected (target %0d)", i_target);
            err_cnt++;
        end else begin
            c = cmd_expect_q.pop_front();
            check_field("target",      c.target,      i_target);
            check_field("direction",   c.direction,   i_direction);
            check_field("pulse_count", c.pulse_count, i_pulse_count);
            check_field("speed",       c.speed,       i_speed);
            check_field("accel",       c.accel,       i_accel);
            check_field("servo_angle", c.servo_angle, i_servo_angle);
            check_field("last",        c.last,        i_last);
            checked_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            speed_reg = SPEED_RESET;
            accel_reg = ACCEL_RESET;
            rx_phase  = PH_HEADER;
            rx_count  = 0;
            foreach (payload_buf[i]) payload_buf[i] = 8'h00;
            cmd_expect_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MOTOR_SPEED: speed_reg = i_cfg_data;
                    CFG_MOTOR_ACCEL: accel_reg = i_cfg_data[ACCEL_W-1:0];
                    default: ;   // drop writes to unmapped indexes
                endcase
            end
            if (i_in_valid && !i_in_stall)
                absorb_byte(i_rx_byte);
            if (i_out_valid && !i_out_stall)
                compare_command();
        end
        o_pending <= cmd_expect_q.size();
        o_errors  <= err_cnt;
        o_checked <= checked_cnt;
    end

endmodule

>>> bench/tb_top.sv
// Testbench top for the joint frame deframer: clock, reset, byte and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
    import jfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BYTES    = 130;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  in_valid    = 1'b0;
    logic [7:0]            rx_byte     = 8'h00;
    logic                  out_stall   = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [SPEED_W-1:0]    cfg_data    = '0;

    wire                       in_stall;
    wire                       out_valid;
    wire  [TARGET_W-1:0]       target;
    wire                       direction;
    wire  [PULSE_W-1:0]        pulse_count;
    wire  [SPEED_W-1:0]        speed;
    wire  [ACCEL_W-1:0]        accel;
    wire signed [SERVO_W-1:0]  servo_angle;
    wire                       last;
    wire                       cfg_ready;

    int errors;
    int pending;
    int checked;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;
    int frames_sent   = 0;
    int reg_writes    = 0;
    int idle_cycles   = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    joint_frame_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_rx_byte     (rx_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_target      (target),
        .o_direction   (direction),
        .o_pulse_count (pulse_count),
        .o_speed       (speed),
        .o_accel       (accel),
        .o_servo_angle (servo_angle),
        .o_last        (last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    jfd_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_rx_byte     (rx_byte),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_target      (target),
        .i_direction   (direction),
        .i_pulse_count (pulse_count),
        .i_speed       (speed),
        .i_accel       (accel),
        .i_servo_angle (servo_angle),
        .i_last        (last),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Count cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Hold the input until every command is out and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPEED_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        reg_writes++;
    endtask

    task automatic configure(input logic [SPEED_W-1:0] spd, input logic [SPEED_W-1:0] acc);
        write_reg(CFG_MOTOR_SPEED, spd);
        write_reg(CFG_MOTOR_ACCEL, acc);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == avoid) ? ~b : b;
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(input logic [7:0] pl [PAYLOAD_BYTES], input int junk);
        send_byte(HDR_BYTE);
        foreach (pl[i]) send_byte(pl[i]);
        repeat (junk) send_byte(byte_other_than(TRL_BYTE));
        send_byte(TRL_BYTE);
        frames_sent++;
    endtask

    task automatic random_traffic();
        logic [7:0]  pl [PAYLOAD_BYTES];
        logic [15:0] ang;
        int          roll;
        int          n;
        roll = $urandom_range(99);
        for (int k = 0; k < PAYLOAD_BYTES / 2; k++) begin
            ang         = pick_angle();
            pl[2*k]     = ang[15:8];
            pl[2*k + 1] = ang[7:0];
        end
        if (roll < 80) begin
            repeat ($urandom_range(1)) send_byte(byte_other_than(HDR_BYTE));
            send_frame(pl, ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
        end else if (roll < 90) begin
            // truncated frame: whatever follows is absorbed as payload
            n = $urandom_range(1, PAYLOAD_BYTES - 1);
            send_byte(HDR_BYTE);
            for (int i = 0; i < n; i++) send_byte(pl[i]);
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end
    endtask

    task automatic random_phase(input int goal);
        int half;
        half = bytes_sent + goal / 2;
        while (bytes_sent < half) random_traffic();
        drain();
        half = bytes_sent + goal / 2;
        while (bytes_sent < half) random_traffic();
        drain();
    endtask

    initial begin
        logic [7:0] pl [PAYLOAD_BYTES];

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 12;
        recv_idle_pct = 64;

        // Reset register values; full-scale negative and positive, zero and minus one,
        // markers stored as data, junk while waiting for the trailer
        pl = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF,
               8'hA5, 8'h66, 8'h80, 8'h00};
        send_byte(TRL_BYTE);
        send_byte(8'h00);
        send_frame(pl, 1);
        drain();

        write_reg(CFG_MOTOR_SPEED, 13'd5000);
        write_reg(CFG_MOTOR_ACCEL, 13'd255);
        write_reg(CFG_SPARE_2, 13'h1FFF);
        write_reg(CFG_SPARE_3, 13'h0000);
        cfg_valid <= 1'b0;

        pl = '{8'h00, 8'h01, 8'hFF, 8'hFE, 8'h7F, 8'hFF, 8'h80, 8'h00,
               8'h66, 8'hA5, 8'h7F, 8'hFF};
        send_byte(8'hFF);
        send_frame(pl, 0);
        drain();

        configure(13'd0, 13'd0);
        random_phase(PHASE_BYTES);

        send_idle_pct = 64;
        recv_idle_pct = 12;
        // Out of range speed and an accel value wider than its register
        configure(13'h1FFF, 13'h1ABC);
        random_phase(PHASE_BYTES);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(13'($urandom_range(5000)), 13'($urandom_range(255)));
        random_phase(PHASE_BYTES);

        $display("Sent %0d bytes holding %0d complete frames, %0d register writes.",
                 bytes_sent, frames_sent, reg_writes);
        $display("Checked %0d joint commands across three stall mixes.", checked);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d commands outstanding", errors, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/jfd_pkg.sv
hw/rtl/joint_frame_deframer.sv
bench/jfd_checker.sv
bench/tb_top.sv
